// File: rtl/cdsc_pkg.sv
// ----------------------------------------------------------------------------
// cdsc_pkg
// Shared types, codes and a helper function for the contact debounce and
// speaker control core.
// ----------------------------------------------------------------------------
package cdsc_pkg;

   localparam int NUM_LANES = 3;

   // Item command codes.
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_ACCESS = 1'b1;

   // Voice bus modes with their own speaker behavior.
   localparam logic [3:0] MODE_CAB   = 4'd0;
   localparam logic [3:0] MODE_MIC   = 4'd1;
   localparam logic [3:0] MODE_RADIO = 4'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_STABLE_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_MAIN_PTT_BIT     = 3'd1;
   localparam logic [2:0] CSR_AUX_PTT_BIT      = 3'd2;
   localparam logic [2:0] CSR_MAIN_SPEAKER_BIT = 3'd3;
   localparam logic [2:0] CSR_AUX_SPEAKER_BIT  = 3'd4;

   // Configuration reset values.
   localparam logic [3:0] RST_STABLE_THRESHOLD = 4'd2;
   localparam logic [2:0] RST_MAIN_PTT_BIT     = 3'd0;
   localparam logic [2:0] RST_AUX_PTT_BIT      = 3'd1;
   localparam logic [4:0] RST_MAIN_SPEAKER_BIT = 5'd0;
   localparam logic [4:0] RST_AUX_SPEAKER_BIT  = 5'd1;

   localparam logic [4:0] LATCH_BITS = 5'd24;

   typedef struct packed {
      logic [3:0] stable_threshold;
      logic [2:0] main_ptt_bit;
      logic [2:0] aux_ptt_bit;
      logic [4:0] main_speaker_bit;
      logic [4:0] aux_speaker_bit;
   } cfg_type;

   typedef struct packed {
      logic [7:0] published;
      logic [7:0] rising;
   } lane_result_type;

   typedef struct packed {
      logic [23:0] debounced;
      logic [23:0] rising;
      logic [7:0]  port_one;
      logic [7:0]  port_two;
      logic [7:0]  port_three;
      logic        reset_request;
   } rsp_type;

   // One-hot latch mask for a speaker bit; positions past the latch select nothing.
   function automatic logic [23:0] spk_mask(input logic [4:0] bit_pos);
      logic [23:0] mask;
      mask = '0;
      if (bit_pos < LATCH_BITS) begin
         mask = 24'(1) << bit_pos;
      end
      return mask;
   endfunction

endpackage

// File: rtl/cdsc_lane.sv
// ----------------------------------------------------------------------------
// cdsc_lane
// Debounce and rising-edge detection for one contact byte.
// ----------------------------------------------------------------------------
module cdsc_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      sample_en,
   input  logic [7:0]                raw,
   input  logic [3:0]                threshold,
   output cdsc_pkg::lane_result_type result
);
   import cdsc_pkg::*;

   logic [7:0] last_raw_ff, last_raw_in;
   logic [3:0] hold_count_ff, hold_count_in;
   logic [7:0] published_ff, published_in;

   always_comb begin
      last_raw_in   = last_raw_ff;
      hold_count_in = hold_count_ff;
      published_in  = published_ff;
      if (sample_en) begin
         if (raw != last_raw_ff) begin
            hold_count_in = '0;
            last_raw_in   = raw;
         end else if (hold_count_ff >= threshold) begin
            published_in = raw;
         end else begin
            hold_count_in = hold_count_ff + 4'd1;
         end
      end
   end

   // The previously published value is always the one held in published_ff,
   // so the edge is taken against it directly.
   assign result.published = published_in;
   assign result.rising    = sample_en ? (published_in & ~published_ff) : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff   <= '0;
         hold_count_ff <= '0;
         published_ff  <= '0;
      end else begin
         last_raw_ff   <= last_raw_in;
         hold_count_ff <= hold_count_in;
         published_ff  <= published_in;
      end
   end

endmodule

// File: rtl/cdsc_merge.sv
// ----------------------------------------------------------------------------
// cdsc_merge
// Combines the lane results, runs the speaker control and holds the output
// latch, and forms the result item.
// ----------------------------------------------------------------------------
module cdsc_merge (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              fire,
   input  logic                                              cmd,
   input  logic                                              unit_active,
   input  logic [3:0]                                        bus_mode,
   input  logic [23:0]                                       set_bits,
   input  logic [23:0]                                       clear_bits,
   input  cdsc_pkg::cfg_type                                 cfg,
   input  cdsc_pkg::lane_result_type [cdsc_pkg::NUM_LANES-1:0] lanes,
   output cdsc_pkg::rsp_type                                 rsp
);
   import cdsc_pkg::*;

   // Latch is kept in set/clear layout: [15:8] port one, [7:0] port two,
   // [23:16] port three.
   logic [23:0] latch_ff, latch_in;
   logic [23:0] spk_latch, cab_step;
   logic [23:0] mspk, aspk;
   logic [7:0]  third;
   logic        mptt, aptt, spk_reset_req, reset_req;

   always_comb begin
      third = lanes[2].published;
      mptt  = third[cfg.main_ptt_bit];
      aptt  = third[cfg.aux_ptt_bit];
      mspk  = spk_mask(cfg.main_speaker_bit);
      aspk  = spk_mask(cfg.aux_speaker_bit);

      cab_step      = mptt ? (latch_ff & ~mspk) : (latch_ff | mspk);
      spk_latch     = latch_ff;
      spk_reset_req = 1'b0;
      unique case (bus_mode)
         MODE_CAB: begin
            spk_latch     = aptt ? (cab_step & ~aspk) : (cab_step | aspk);
            spk_reset_req = aptt;
         end
         MODE_MIC: begin
            if (mptt || aptt) begin
               spk_latch     = latch_ff & ~(mspk | aspk);
               spk_reset_req = 1'b1;
            end
         end
         MODE_RADIO: begin
            spk_latch     = (latch_ff & ~mspk) | aspk;
            spk_reset_req = mptt || aptt;
         end
         default: begin
            spk_latch = latch_ff | mspk | aspk;
         end
      endcase

      latch_in  = latch_ff;
      reset_req = 1'b0;
      if (fire) begin
         if (cmd == CMD_ACCESS) begin
            latch_in = (latch_ff & ~clear_bits) | set_bits;
         end else if (unit_active) begin
            latch_in  = spk_latch;
            reset_req = spk_reset_req;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         rsp.debounced[8*i +: 8] = lanes[i].published;
         rsp.rising[8*i +: 8]    = lanes[i].rising;
      end
      rsp.port_one      = latch_in[15:8];
      rsp.port_two      = ~latch_in[7:0];
      rsp.port_three    = latch_in[23:16];
      rsp.reset_request = reset_req;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= '0;
      end else begin
         latch_ff <= latch_in;
      end
   end

endmodule

// File: rtl/contact_debounce_speaker_control_core.sv
// Latency: a result item appears in the cycle after its item is accepted.
// Throughput: one item per cycle while rsp_stall is low or no result is held;
// the three byte lanes and the speaker logic are all combinational, and the
// output register lets a new item in while the previous result is taken.
// Reset: synchronous; clears all debounce state and the output latch and
// restores the configuration defaults.
// ----------------------------------------------------------------------------
// contact_debounce_speaker_control_core
// Three parallel contact debounce lanes with edge detection, merged into
// monitor speaker control and an output latch with three ports.
// ----------------------------------------------------------------------------
module contact_debounce_speaker_control_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_raw_first,
   input  logic [7:0]  req_raw_second,
   input  logic [7:0]  req_raw_third,
   input  logic        req_unit_active,
   input  logic [3:0]  req_bus_mode,
   input  logic [23:0] req_set_bits,
   input  logic [23:0] req_clear_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_debounced,
   output logic [23:0] rsp_rising,
   output logic [7:0]  rsp_port_one,
   output logic [7:0]  rsp_port_two,
   output logic [7:0]  rsp_port_three,
   output logic        rsp_reset_request,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [4:0]  csr_write_data
);
   import cdsc_pkg::*;

   cfg_type                          cfg_ff, cfg_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   rsp_type                          rsp_ff, rsp_in;
   lane_result_type [NUM_LANES-1:0]  lanes;
   logic [NUM_LANES-1:0][7:0]        raw;
   logic                             fire, sample_en;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_STABLE_THRESHOLD: cfg_in.stable_threshold = csr_write_data[3:0];
            CSR_MAIN_PTT_BIT:     cfg_in.main_ptt_bit     = csr_write_data[2:0];
            CSR_AUX_PTT_BIT:      cfg_in.aux_ptt_bit      = csr_write_data[2:0];
            CSR_MAIN_SPEAKER_BIT: cfg_in.main_speaker_bit = csr_write_data;
            CSR_AUX_SPEAKER_BIT:  cfg_in.aux_speaker_bit  = csr_write_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign fire      = req_valid && !req_stall;
   assign sample_en = fire && (req_cmd == CMD_TICK);
   assign raw       = {req_raw_third, req_raw_second, req_raw_first};

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      cdsc_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .sample_en (sample_en),
         .raw       (raw[g]),
         .threshold (cfg_ff.stable_threshold),
         .result    (lanes[g])
      );
   end

   cdsc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .cmd         (req_cmd),
      .unit_active (req_unit_active),
      .bus_mode    (req_bus_mode),
      .set_bits    (req_set_bits),
      .clear_bits  (req_clear_bits),
      .cfg         (cfg_ff),
      .lanes       (lanes),
      .rsp         (rsp_in)
   );

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stable_threshold <= RST_STABLE_THRESHOLD;
         cfg_ff.main_ptt_bit     <= RST_MAIN_PTT_BIT;
         cfg_ff.aux_ptt_bit      <= RST_AUX_PTT_BIT;
         cfg_ff.main_speaker_bit <= RST_MAIN_SPEAKER_BIT;
         cfg_ff.aux_speaker_bit  <= RST_AUX_SPEAKER_BIT;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_debounced     = rsp_ff.debounced;
   assign rsp_rising        = rsp_ff.rising;
   assign rsp_port_one      = rsp_ff.port_one;
   assign rsp_port_two      = rsp_ff.port_two;
   assign rsp_port_three    = rsp_ff.port_three;
   assign rsp_reset_request = rsp_ff.reset_request;

endmodule
